>>> rtl/core/wbscd_pkg.sv
// Shared types and constants for the write-back sector cache directory.
// Used by the directory RAM, the victim scan unit and the top level.
package wbscd_pkg;

  localparam int ENTRIES_DEF  = 4;
  localparam int SECTOR_BYTES = 512;
  localparam int OFF_W        = 9;
  localparam int LEN_W        = 10;
  localparam int TAG_W        = 32;
  localparam int AGE_W        = 16;

  localparam logic [TAG_W-1:0] INVALID_SECTOR = '0;
  localparam logic             DIRTY_SET      = 1'b1;

  typedef enum logic [2:0] {
    ACT_SEEK     = 3'd0,
    ACT_READ     = 3'd1,
    ACT_WRITE    = 3'd2,
    ACT_FLUSH    = 3'd3,
    ACT_FILL_ERR = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    KIND_ACK       = 2'd0,
    KIND_CHUNK     = 2'd1,
    KIND_WRITEBACK = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK,
    ST_SECT,
    ST_SCAN,
    ST_DECIDE,
    ST_FL_SCAN,
    ST_FL_TAG
  } state_e;

  // One directory word: sector tag and the touch stamp it was last used at.
  typedef struct packed {
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] stamp;
  } dir_word_t;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctrl_t;

  typedef struct packed {
    logic hit;
    logic free;
  } scan_res_t;

  typedef struct packed {
    kind_e            kind;
    logic [1:0]       entry;
    logic             hit;
    logic             evict_dirty;
    logic [TAG_W-1:0] writeback_sector;
    logic [TAG_W-1:0] fill_sector;
    logic [OFF_W-1:0] byte_offset;
    logic [LEN_W-1:0] chunk_length;
    logic             last;
  } result_t;

endpackage

>>> rtl/core/wbscd_dir_ram.sv
// Directory RAM: one tag/stamp word per cache entry.
// One write port, one registered read port. Depends on wbscd_pkg.
module wbscd_dir_ram import wbscd_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  dir_word_t     wdata_i,
  input  logic [IW-1:0] raddr_i,
  output dir_word_t     rdata_o
);

  dir_word_t mem [ENTRIES];
  dir_word_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/wbscd_victim_scan.sv
// Shared compare unit: walks the directory one entry per beat and keeps
// the first hit, the first free entry and the oldest entry. Uses wbscd_pkg.
module wbscd_victim_scan import wbscd_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF,
  parameter int IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  scan_ctrl_t       ctrl_i,
  input  logic [TAG_W-1:0] sector_i,
  input  logic [AGE_W-1:0] now_i,
  input  dir_word_t        word_i,
  input  logic             entry_valid_i,
  input  logic [IW-1:0]    idx_i,
  output scan_res_t        res_o,
  output logic [IW-1:0]    hit_idx_o,
  output logic [IW-1:0]    free_idx_o,
  output logic [IW-1:0]    vict_idx_o,
  output logic [TAG_W-1:0] vict_tag_o
);

  scan_res_t        res_q, res_d;
  logic [IW-1:0]    hit_idx_q, hit_idx_d;
  logic [IW-1:0]    free_idx_q, free_idx_d;
  logic [IW-1:0]    vict_idx_q, vict_idx_d;
  logic [TAG_W-1:0] vict_tag_q, vict_tag_d;
  logic [AGE_W-1:0] oldest_q, oldest_d;
  logic [AGE_W-1:0] age;

  assign age = now_i - word_i.stamp;

  always_comb begin
    res_d      = res_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    vict_idx_d = vict_idx_q;
    vict_tag_d = vict_tag_q;
    oldest_d   = oldest_q;
    if (ctrl_i.clear) begin
      res_d      = '0;
      vict_idx_d = '0;
      vict_tag_d = '0;
      oldest_d   = '0;
    end else if (ctrl_i.step) begin
      if (!res_q.hit && sector_i != INVALID_SECTOR && entry_valid_i &&
          word_i.tag == sector_i) begin
        res_d.hit = 1'b1;
        hit_idx_d = idx_i;
      end
      if (!res_q.free && !entry_valid_i) begin
        res_d.free = 1'b1;
        free_idx_d = idx_i;
      end
      // later entries win ties
      if (age >= oldest_q) begin
        oldest_d   = age;
        vict_idx_d = idx_i;
        vict_tag_d = word_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    vict_idx_q <= vict_idx_d;
    vict_tag_q <= vict_tag_d;
    oldest_q   <= oldest_d;
  end

  assign res_o      = res_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;
  assign vict_idx_o = vict_idx_q;
  assign vict_tag_o = vict_tag_q;

endmodule

>>> rtl/core/write_back_sector_cache_directory.sv
// Top level: sequencer, cursor, valid/dirty bits and result register of the
// sector cache directory. Uses wbscd_pkg, wbscd_dir_ram, wbscd_victim_scan.
//
//   channel  | handshake              | payload
//   ---------+------------------------+------------------------------------
//   cfg      | cfg_we_i               | cfg_wdata_i (start sector)
//   in       | in_valid_i / in_stall_o | action, address, length, failed_entry
//   out      | out_valid_o / out_stall_i | kind .. last, one beat per result
//
// Seek, fill error and unknown actions, and reads/writes of length zero, answer
// with one ack. A read/write is split into sector chunks; each chunk walks the
// directory through the one RAM read port (SECT, SCAN, DECIDE); a flush walks it
// once and stops in FL_TAG at each dirty entry. Output stalls can hold any of these.
// Reset empties the directory at once (valid bits), no clearing pass.
// A stalled result holds the output register; the sequencer waits for it.
module write_back_sector_cache_directory import wbscd_pkg::*; #(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TAG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [2:0]       action_i,
  input  logic [31:0]      address_i,
  input  logic [LEN_W-1:0] length_i,
  input  logic [1:0]       failed_entry_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [1:0]       kind_o,
  output logic [1:0]       entry_o,
  output logic             hit_o,
  output logic             evict_dirty_o,
  output logic [TAG_W-1:0] writeback_sector_o,
  output logic [TAG_W-1:0] fill_sector_o,
  output logic [OFF_W-1:0] byte_offset_o,
  output logic [LEN_W-1:0] chunk_length_o,
  output logic             last_o
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0]    CNT_END  = CW'(ENTRIES);
  localparam logic [LEN_W-1:0] SECT_LEN = LEN_W'(SECTOR_BYTES);

  state_e           state_q, state_d;
  logic [TAG_W-1:0] start_q, start_d;
  logic [31:0]      cursor_q, cursor_d;
  logic [AGE_W-1:0] now_q, now_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [ENTRIES-1:0] dirty_q, dirty_d;
  logic [2:0]       action_q, action_d;
  logic [LEN_W-1:0] remain_q, remain_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [IW-1:0]    rd_idx_q;
  logic [TAG_W-1:0] sector_q, sector_d;
  logic [OFF_W-1:0] off_q, off_d;
  logic [LEN_W-1:0] clen_q, clen_d;
  logic             pend_q, pend_d;
  logic [IW-1:0]    pend_idx_q, pend_idx_d;
  logic [TAG_W-1:0] pend_tag_q, pend_tag_d;
  logic             out_valid_q, out_valid_d;
  result_t          res_q, res_d;

  logic             accept;
  logic             out_free;
  logic [IW-1:0]    cnt_idx;
  logic [IW-1:0]    fail_idx;
  logic [LEN_W-1:0] room;
  logic [LEN_W-1:0] len_sat;
  logic [IW-1:0]    use_idx;
  logic             evict;

  logic             ram_we;
  dir_word_t        ram_wdata;
  dir_word_t        ram_rdata;
  scan_ctrl_t       scan_ctrl;
  scan_res_t        scan_res;
  logic [IW-1:0]    hit_idx, free_idx, vict_idx;
  logic [TAG_W-1:0] vict_tag;

  assign accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign cnt_idx  = cnt_q[IW-1:0];
  assign fail_idx = IW'(failed_entry_i);
  assign room     = SECT_LEN - {1'b0, cursor_q[OFF_W-1:0]};
  assign len_sat  = (length_i > SECT_LEN) ? SECT_LEN : length_i;
  assign use_idx  = scan_res.hit ? hit_idx : (scan_res.free ? free_idx : vict_idx);
  assign evict    = !scan_res.hit && !scan_res.free && dirty_q[vict_idx];

  wbscd_dir_ram #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (use_idx),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_idx),
    .rdata_o (ram_rdata)
  );

  wbscd_victim_scan #(
    .ENTRIES (ENTRIES),
    .IW      (IW)
  ) u_victim_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (scan_ctrl),
    .sector_i      (sector_q),
    .now_i         (now_q),
    .word_i        (ram_rdata),
    .entry_valid_i (valid_q[rd_idx_q]),
    .idx_i         (rd_idx_q),
    .res_o         (scan_res),
    .hit_idx_o     (hit_idx),
    .free_idx_o    (free_idx),
    .vict_idx_o    (vict_idx),
    .vict_tag_o    (vict_tag)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (action_e'(action_i))
            ACT_READ, ACT_WRITE: state_d = (len_sat == '0) ? ST_ACK : ST_SECT;
            ACT_FLUSH:           state_d = ST_FL_SCAN;
            default:             state_d = ST_ACK;
          endcase
        end
      end
      ST_ACK: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_SECT: state_d = ST_SCAN;
      ST_SCAN: begin
        if (cnt_q == CNT_END) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          state_d = (remain_q == clen_q) ? ST_IDLE : ST_SECT;
        end
      end
      ST_FL_SCAN: begin
        if (cnt_q == CNT_END) begin
          if (out_free) begin
            state_d = ST_IDLE;
          end
        end else if (valid_q[cnt_idx] && dirty_q[cnt_idx]) begin
          state_d = ST_FL_TAG;
        end
      end
      ST_FL_TAG: begin
        if (!pend_q || out_free) begin
          state_d = ST_FL_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    start_d    = cfg_we_i ? cfg_wdata_i : start_q;
    cursor_d   = cursor_q;
    now_d      = now_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    action_d   = action_q;
    remain_d   = remain_q;
    cnt_d      = cnt_q;
    sector_d   = sector_q;
    off_d      = off_q;
    clen_d     = clen_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    pend_tag_d = pend_tag_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    ram_wdata  = '{tag: sector_q, stamp: now_q + AGE_W'(1)};
    scan_ctrl  = '0;
    in_stall_o = (state_q != ST_IDLE);

    // drop the result once it is taken
    out_valid_d = out_valid_q && out_stall_i;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          action_d = action_i;
          remain_d = len_sat;
          cnt_d    = '0;
          pend_d   = 1'b0;
          case (action_e'(action_i))
            ACT_SEEK: cursor_d = address_i;
            ACT_FILL_ERR: begin
              if ({30'd0, failed_entry_i} < 32'(ENTRIES)) begin
                valid_d[fail_idx] = 1'b0;
                dirty_d[fail_idx] = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACK: begin
        if (out_free) begin
          res_d       = '0;
          res_d.kind  = KIND_ACK;
          res_d.last  = 1'b1;
          out_valid_d = 1'b1;
        end
      end
      ST_SECT: begin
        sector_d        = start_q + (cursor_q >> OFF_W);
        off_d           = cursor_q[OFF_W-1:0];
        clen_d          = (remain_q < room) ? remain_q : room;
        cnt_d           = '0;
        scan_ctrl.clear = 1'b1;
      end
      ST_SCAN: begin
        scan_ctrl.step = (cnt_q != '0);
        if (cnt_q != CNT_END) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_DECIDE: begin
        if (out_free) begin
          ram_we            = 1'b1;
          now_d             = now_q + AGE_W'(1);
          valid_d[use_idx]  = (sector_q != INVALID_SECTOR);
          if (action_e'(action_q) == ACT_WRITE) begin
            dirty_d[use_idx] = DIRTY_SET;
          end else if (!scan_res.hit) begin
            dirty_d[use_idx] = 1'b0;
          end
          cursor_d               = cursor_q + 32'(clen_q);
          remain_d               = remain_q - clen_q;
          res_d.kind             = KIND_CHUNK;
          res_d.entry            = 2'(use_idx);
          res_d.hit              = scan_res.hit;
          res_d.evict_dirty      = evict;
          res_d.writeback_sector = evict ? vict_tag : '0;
          res_d.fill_sector      = scan_res.hit ? '0 : sector_q;
          res_d.byte_offset      = off_q;
          res_d.chunk_length     = clen_q;
          res_d.last             = (remain_q == clen_q);
          out_valid_d            = 1'b1;
        end
      end
      ST_FL_SCAN: begin
        if (cnt_q == CNT_END) begin
          if (out_free) begin
            res_d       = '0;
            res_d.last  = 1'b1;
            out_valid_d = 1'b1;
            if (pend_q) begin
              res_d.kind             = KIND_WRITEBACK;
              res_d.entry            = 2'(pend_idx_q);
              res_d.writeback_sector = pend_tag_q;
            end else begin
              res_d.kind = KIND_ACK;
            end
          end
        end else if (!(valid_q[cnt_idx] && dirty_q[cnt_idx])) begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_FL_TAG: begin
        // hold the found entry until the next one shows whether it is last
        if (!pend_q || out_free) begin
          if (pend_q) begin
            res_d                  = '0;
            res_d.kind             = KIND_WRITEBACK;
            res_d.entry            = 2'(pend_idx_q);
            res_d.writeback_sector = pend_tag_q;
            out_valid_d            = 1'b1;
          end
          pend_d           = 1'b1;
          pend_idx_d       = cnt_idx;
          pend_tag_d       = ram_rdata.tag;
          dirty_d[cnt_idx] = 1'b0;
          cnt_d            = cnt_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= TAG_W'(1);
      cursor_q    <= '0;
      now_q       <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      start_q     <= start_d;
      cursor_q    <= cursor_d;
      now_q       <= now_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q   <= action_d;
    remain_q   <= remain_d;
    rd_idx_q   <= cnt_idx;
    sector_q   <= sector_d;
    off_q      <= off_d;
    clen_q     <= clen_d;
    pend_idx_q <= pend_idx_d;
    pend_tag_q <= pend_tag_d;
    res_q      <= res_d;
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = res_q.kind;
  assign entry_o            = res_q.entry;
  assign hit_o              = res_q.hit;
  assign evict_dirty_o      = res_q.evict_dirty;
  assign writeback_sector_o = res_q.writeback_sector;
  assign fill_sector_o      = res_q.fill_sector;
  assign byte_offset_o      = res_q.byte_offset;
  assign chunk_length_o     = res_q.chunk_length;
  assign last_o             = res_q.last;

endmodule
